// ===== design/rmd_pkg.sv =====
// Running median detrend: shared constants, types and helpers.
// Used by rmd_cell and running_median_detrend_unit; depends on nothing.

package rmd_pkg;

	localparam int MAX_HALF_WIDTH = 63;
	localparam int HALF_RESET     = 30;
	localparam int DEPTH          = 2 * MAX_HALF_WIDTH + 1;
	localparam int IDX_W          = $clog2(DEPTH);
	localparam int CNT_W          = $clog2(DEPTH + 1);
	localparam int HALF_W         = $clog2(MAX_HALF_WIDTH + 1);
	localparam int CFG_W          = 6;
	localparam int SAMPLE_W       = 16;
	localparam int RESID_W        = SAMPLE_W + 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [RESID_W-1:0]  resid_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [HALF_W-1:0]          half_t;
	typedef logic [CFG_W-1:0]           cfg_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_DROP,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		sample_t  key;
		idx_t     n;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_INSERT,
		ST_MEDIAN,
		ST_EMIT
	} state_t;

	// Clamp a raw half-width code into 1..MAX_HALF_WIDTH.
	function automatic half_t eff_half(cfg_t raw);
		int unsigned h;
		h = int'(raw);
		if (h < 1)
			h = 1;
		if (h > MAX_HALF_WIDTH)
			h = MAX_HALF_WIDTH;
		return HALF_W'(h);
	endfunction

endpackage

// ===== design/rmd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.

module rmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 127,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rmd_cell.sv =====
// One entry of the sorted window: holds a value, shifts toward its neighbors.
// Depends on rmd_pkg.

module rmd_cell (
	input  logic               clk,
	input  rmd_pkg::cell_ctl_t ctl,
	input  rmd_pkg::idx_t      idx,
	input  rmd_pkg::sample_t   left_val,
	input  logic               left_gt,
	input  rmd_pkg::sample_t   right_val,
	output rmd_pkg::sample_t   val,
	output logic               gt
);

	rmd_pkg::sample_t val_q;

	// Entries past the occupied count act as larger than any key.
	assign gt  = (idx >= ctl.n) || (val_q > ctl.key);
	assign val = val_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			rmd_pkg::CELL_HOLD: begin
			end
			rmd_pkg::CELL_DROP: begin
				// close the gap left by the removed value
				if (val_q >= ctl.key)
					val_q <= right_val;
			end
			rmd_pkg::CELL_INSERT: begin
				// first larger entry takes the key, the rest shift right
				if (gt)
					val_q <= left_gt ? left_val : ctl.key;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/running_median_detrend_unit.sv =====
// Running median detrend top level: history RAM, sorted cell row, sequencer.
// Depends on rmd_pkg, rmd_ram and rmd_cell.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------
//  sample   | in        | sample_valid / sample_stall | sample[15:0], restart
//  result   | out       | result_valid / result_stall | residual[16:0], median
//  config   | in        | cfg_we (no wait)            | cfg_wdata[5:0] half width
//
// Each transfer runs through these steps in order: accept (history read of the
// oldest slot), drop pass over the cell row, insert pass over the cell row,
// median select, emit.
// A stalled result register holds the block in the emit step until it drains;
// a new sample is taken while the last result still waits.
// Reset empties the window at once; the stores need no clearing pass.

module running_median_detrend_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [5:0]             cfg_wdata,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic signed [15:0]     sample,
	input  logic                   restart,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [16:0]     residual,
	output logic signed [15:0]     median
);

	// Window configuration
	rmd_pkg::half_t     h_q;
	rmd_pkg::cnt_t      w_q;

	// Window position
	rmd_pkg::idx_t      ptr_q;
	rmd_pkg::cnt_t      fill_q;

	// Item in flight
	rmd_pkg::state_t    state_q, state_d;
	rmd_pkg::sample_t   sample_q;
	rmd_pkg::idx_t      wptr_q;
	rmd_pkg::idx_t      n_q;
	logic               full_q;
	logic               emit_q;
	rmd_pkg::sample_t   centre_q;
	rmd_pkg::sample_t   median_q;

	// Result register
	logic               out_valid_q;
	rmd_pkg::resid_t    res_out_q;
	rmd_pkg::sample_t   med_out_q;

	// Combinational
	logic               accept;
	logic               out_load;
	rmd_pkg::idx_t      ptr_eff;
	rmd_pkg::cnt_t      fill_eff;
	rmd_pkg::cnt_t      fill_new;
	logic [rmd_pkg::IDX_W:0] ptr_inc;
	logic [rmd_pkg::IDX_W:0] centre_sum;
	rmd_pkg::idx_t      centre_slot;
	rmd_pkg::idx_t      ram_raddr;
	logic               ram_we;
	logic [rmd_pkg::SAMPLE_W-1:0] ram_rdata;
	rmd_pkg::sample_t   old_val;
	rmd_pkg::cell_ctl_t cell_ctl;
	rmd_pkg::sample_t   median_sel;
	rmd_pkg::half_t     cfg_half;

	rmd_pkg::sample_t   cell_val [rmd_pkg::DEPTH];
	logic               cell_gt  [rmd_pkg::DEPTH];

	assign accept   = sample_valid && !sample_stall;
	assign old_val  = rmd_pkg::sample_t'(ram_rdata);
	assign cfg_half = rmd_pkg::eff_half(cfg_wdata);

	// Restart empties the window ahead of this sample.
	assign ptr_eff  = restart ? '0 : ptr_q;
	assign fill_eff = restart ? '0 : fill_q;
	assign fill_new = (fill_eff < w_q) ? rmd_pkg::CNT_W'(fill_eff + 1'b1) : fill_eff;
	assign ptr_inc  = {1'b0, ptr_eff} + 1'b1;

	// Centre slot: half width past the next write slot, wrapped once.
	assign centre_sum  = {1'b0, ptr_q} + (rmd_pkg::IDX_W + 1)'(h_q);
	assign centre_slot = (centre_sum >= (rmd_pkg::IDX_W + 1)'(w_q))
		? rmd_pkg::IDX_W'(centre_sum - (rmd_pkg::IDX_W + 1)'(w_q))
		: rmd_pkg::IDX_W'(centre_sum);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			rmd_pkg::ST_IDLE: begin
				if (sample_valid)
					state_d = rmd_pkg::ST_DROP;
			end
			rmd_pkg::ST_DROP:   state_d = rmd_pkg::ST_INSERT;
			rmd_pkg::ST_INSERT: state_d = rmd_pkg::ST_MEDIAN;
			rmd_pkg::ST_MEDIAN: state_d = rmd_pkg::ST_EMIT;
			rmd_pkg::ST_EMIT: begin
				if (!emit_q || !out_valid_q || !result_stall)
					state_d = rmd_pkg::ST_IDLE;
			end
			default: state_d = rmd_pkg::ST_IDLE;
		endcase
	end

	// Output logic of the sequencer
	always_comb begin
		sample_stall = 1'b1;
		ram_we       = 1'b0;
		ram_raddr    = ptr_eff;
		out_load     = 1'b0;
		cell_ctl.op  = rmd_pkg::CELL_HOLD;
		cell_ctl.key = sample_q;
		cell_ctl.n   = n_q;
		case (state_q)
			rmd_pkg::ST_IDLE: begin
				// fetch the oldest sample while taking the new one
				sample_stall = 1'b0;
			end
			rmd_pkg::ST_DROP: begin
				// remove the oldest value once the window is full; store the new sample; fetch the centre
				ram_we       = 1'b1;
				ram_raddr    = centre_slot;
				cell_ctl.op  = full_q ? rmd_pkg::CELL_DROP : rmd_pkg::CELL_HOLD;
				cell_ctl.key = old_val;
			end
			rmd_pkg::ST_INSERT: begin
				cell_ctl.op = rmd_pkg::CELL_INSERT;
			end
			rmd_pkg::ST_MEDIAN: begin
			end
			rmd_pkg::ST_EMIT: begin
				out_load = emit_q && (!out_valid_q || !result_stall);
			end
			default: begin
			end
		endcase
	end

	rmd_ram #(
		.WIDTH (rmd_pkg::SAMPLE_W),
		.DEPTH (rmd_pkg::DEPTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sorted window: one cell per entry, ascending from cell zero.
	for (genvar i = 0; i < rmd_pkg::DEPTH; i++) begin : g_cell
		rmd_pkg::sample_t left_val;
		logic             left_gt;
		rmd_pkg::sample_t right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
			assign left_gt  = 1'b0;
		end else begin : g_inner
			assign left_val = cell_val[i-1];
			assign left_gt  = cell_gt[i-1];
		end
		if (i == rmd_pkg::DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_body
			assign right_val = cell_val[i+1];
		end

		rmd_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.idx       (rmd_pkg::IDX_W'(i)),
			.left_val  (left_val),
			.left_gt   (left_gt),
			.right_val (right_val),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	// Median tap: the cell at the half-width position.
	always_comb begin
		median_sel = '0;
		for (int i = 0; i < rmd_pkg::DEPTH; i++) begin
			if (rmd_pkg::IDX_W'(i) == rmd_pkg::IDX_W'(h_q))
				median_sel = median_sel | cell_val[i];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmd_pkg::ST_IDLE;
			h_q         <= rmd_pkg::HALF_W'(rmd_pkg::HALF_RESET);
			w_q         <= rmd_pkg::CNT_W'(2 * rmd_pkg::HALF_RESET + 1);
			ptr_q       <= '0;
			fill_q      <= '0;
			full_q      <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// new window size: empty the window
				h_q    <= cfg_half;
				w_q    <= rmd_pkg::CNT_W'({cfg_half, 1'b1});
				ptr_q  <= '0;
				fill_q <= '0;
			end else if (accept) begin
				ptr_q  <= (ptr_inc == (rmd_pkg::IDX_W + 1)'(w_q))
					? '0 : rmd_pkg::IDX_W'(ptr_inc);
				fill_q <= fill_new;
				full_q <= (fill_eff == w_q);
				emit_q <= (fill_new == w_q);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			wptr_q   <= ptr_eff;
			n_q      <= (fill_eff == w_q)
				? rmd_pkg::IDX_W'(w_q - 1'b1) : rmd_pkg::IDX_W'(fill_eff);
		end
		if (state_q == rmd_pkg::ST_INSERT)
			centre_q <= old_val;
		if (state_q == rmd_pkg::ST_MEDIAN)
			median_q <= median_sel;
		if (out_load) begin
			res_out_q <= rmd_pkg::resid_t'(centre_q) - rmd_pkg::resid_t'(median_q);
			med_out_q <= median_q;
		end
	end

	assign result_valid = out_valid_q;
	assign residual     = res_out_q;
	assign median       = med_out_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w_q)
		else $error("fill count exceeds window size");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rmd_pkg::CNT_W'(ptr_q) < w_q)
		else $error("ring pointer outside window");

	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 (state_q == rmd_pkg::ST_EMIT))
		else $error("sample did not reach emit step in four cycles");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == rmd_pkg::ST_EMIT && emit_q))
		else $error("result raised outside emit step");

endmodule
